FILE: rtl/mbb_pkg.sv
// ----------------------------------------------------------------------------
// mbb_pkg
// Shared types and constants of the monochrome bitmap blit with clipping.
// ----------------------------------------------------------------------------
package mbb_pkg;

    localparam int DISPLAY_WIDTH_DEF  = 1404;
    localparam int DISPLAY_HEIGHT_DEF = 1872;

    localparam int REQ_TYPE_W  = 2;
    localparam int SRC_BITS_W  = 8;
    localparam int READ_ADDR_W = 19;
    localparam int READ_DATA_W = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int BM_DIM_W    = 12;
    localparam int OFFSET_W    = 13;
    localparam int COL_BYTE_W  = 9;

    // request types
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_SRC   = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITMAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y      = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic take;      // input ready
        logic calc;      // clip and cursor step
        logic mul;       // row times display width
        logic addr;      // byte address and pixel mask
        logic rd_a;
        logic wr_a;
        logic rd_b;
        logic wr_b;
        logic clr_step;  // zero one framebuffer byte
        logic rd_fb;     // framebuffer read for a read request
        logic out_load;  // load result register
    } mbb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic                  in_valid;
        logic [REQ_TYPE_W-1:0] req_type;
        logic                  src_skip;
        logic                  clr_last;
        logic                  out_full;
    } mbb_stat_t;

endpackage

FILE: rtl/mbb_if.sv
// ----------------------------------------------------------------------------
// mbb channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mbb_req_if;
    logic                               valid;
    logic                               ready;
    logic [mbb_pkg::REQ_TYPE_W-1:0]     req_type;
    logic [mbb_pkg::SRC_BITS_W-1:0]     src_bits;
    logic [mbb_pkg::READ_ADDR_W-1:0]    read_addr;

    modport source (output valid, output req_type, output src_bits, output read_addr,
                    input ready);
    modport sink   (input valid, input req_type, input src_bits, input read_addr,
                    output ready);
endinterface

interface mbb_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [mbb_pkg::READ_DATA_W-1:0]    read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

interface mbb_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mbb_pkg::CFG_IDX_W-1:0]      index;
    logic [mbb_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/mbb_ctrl.sv
// ----------------------------------------------------------------------------
// mbb_ctrl
// Sequencer: clear sweep, source byte read-modify-write, framebuffer read.
// ----------------------------------------------------------------------------
module mbb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  mbb_pkg::mbb_stat_t stat,
    output mbb_pkg::mbb_cmd_t  cmd
);
    import mbb_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_ADDR,
        ST_RD_A,
        ST_WR_A,
        ST_RD_B,
        ST_WR_B,
        ST_FB_RD,
        ST_FB_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    case (stat.req_type)
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_SRC:   state_next = stat.src_skip ? ST_IDLE : ST_CALC;
                        REQ_READ:  state_next = ST_FB_RD;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CALC:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_ADDR;
            ST_ADDR:   state_next = ST_RD_A;
            ST_RD_A:   state_next = ST_WR_A;
            ST_WR_A:   state_next = ST_RD_B;
            ST_RD_B:   state_next = ST_WR_B;
            ST_WR_B:   state_next = ST_IDLE;
            ST_FB_RD:  state_next = ST_FB_OUT;
            ST_FB_OUT:
            begin
                // hold until the result register frees up
                if (!stat.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.take     = (state_reg == ST_IDLE);
        cmd.calc     = (state_reg == ST_CALC);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.addr     = (state_reg == ST_ADDR);
        cmd.rd_a     = (state_reg == ST_RD_A);
        cmd.wr_a     = (state_reg == ST_WR_A);
        cmd.rd_b     = (state_reg == ST_RD_B);
        cmd.wr_b     = (state_reg == ST_WR_B);
        cmd.clr_step = (state_reg == ST_CLEAR);
        cmd.rd_fb    = (state_reg == ST_FB_RD);
        cmd.out_load = (state_reg == ST_FB_OUT) && !stat.out_full;
    end

endmodule

FILE: rtl/mbb_datapath.sv
// ----------------------------------------------------------------------------
// mbb_datapath
// Configuration, source cursor, clipping, address math, framebuffer memory
// and result register.
// ----------------------------------------------------------------------------
module mbb_datapath
#(
    parameter int DISPLAY_WIDTH  = mbb_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = mbb_pkg::DISPLAY_HEIGHT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    mbb_req_if.sink            req,
    mbb_rsp_if.source          rsp,
    mbb_cfg_if.sink            cfg,
    input  mbb_pkg::mbb_cmd_t  cmd,
    output mbb_pkg::mbb_stat_t stat
);
    import mbb_pkg::*;

    localparam int FB_BYTES = (DISPLAY_WIDTH * DISPLAY_HEIGHT + 7) / 8;
    localparam int FB_AW    = $clog2(FB_BYTES);
    localparam int PIX_W    = 15;
    localparam int BASE_RAW = $clog2(DISPLAY_WIDTH * DISPLAY_HEIGHT) + 2;
    localparam int BASE_W   = (BASE_RAW > PIX_W) ? BASE_RAW : PIX_W;
    localparam int CMP_W    = ((FB_AW > READ_ADDR_W) ? FB_AW : READ_ADDR_W) + 1;

    localparam logic signed [PIX_W-1:0] DW_S = PIX_W'(DISPLAY_WIDTH);
    localparam logic signed [PIX_W-1:0] DH_S = PIX_W'(DISPLAY_HEIGHT);
    localparam logic [FB_AW-1:0]        CLR_LAST = FB_AW'(FB_BYTES - 1);

    // configuration
    logic        [BM_DIM_W-1:0]   width_reg;
    logic        [BM_DIM_W-1:0]   height_reg;
    logic signed [OFFSET_W-1:0]   offx_reg;
    logic signed [OFFSET_W-1:0]   offy_reg;

    // source cursor
    logic [BM_DIM_W-1:0]          row_reg;
    logic [COL_BYTE_W-1:0]        col_reg;

    // latched request
    logic [SRC_BITS_W-1:0]        byte_reg;
    logic [READ_ADDR_W-1:0]       raddr_reg;
    logic                         raddr_ok_reg;

    // blit pipeline
    logic [7:0]                   mask8_reg;
    logic [7:0]                   mask8_next;
    logic [BM_DIM_W-1:0]          dy_reg;
    logic signed [PIX_W-1:0]      dx0_reg;
    logic signed [PIX_W-1:0]      dx0_next;
    logic signed [PIX_W-1:0]      dy_next;
    logic [BASE_W-1:0]            prod_reg;
    logic signed [BASE_W-1:0]     base;
    logic [FB_AW-1:0]             addr_a_reg;
    logic [FB_AW-1:0]             addr_b;
    logic [15:0]                  mask16_reg;

    // cursor step
    logic [COL_BYTE_W:0]          stride;
    logic [COL_BYTE_W:0]          col_inc;

    // clear sweep and memory
    logic [FB_AW-1:0]             clr_cnt_reg;
    logic [7:0]                   mem [FB_BYTES];
    logic [7:0]                   rdata_reg;
    logic                         mem_we;
    logic [FB_AW-1:0]             mem_waddr;
    logic [7:0]                   mem_wdata;
    logic                         mem_re;
    logic [FB_AW-1:0]             mem_raddr;

    // result
    logic                         out_valid_reg;
    logic [READ_DATA_W-1:0]       out_data_reg;

    logic                         take_beat;

    assign take_beat = req.valid && cmd.take;
    assign req.ready = cmd.take;
    assign cfg.ready = 1'b1;

    assign stat.in_valid = req.valid;
    assign stat.req_type = req.req_type;
    assign stat.src_skip = (width_reg == '0) || (row_reg >= height_reg);
    assign stat.clr_last = (clr_cnt_reg == CLR_LAST);
    assign stat.out_full = out_valid_reg && !rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

    // clip the eight pixels of the current byte against bitmap and display
    always_comb
    begin
        logic [BM_DIM_W-1:0]     x0;
        logic [BM_DIM_W:0]       x_b;
        logic signed [PIX_W-1:0] dx_b;
        logic                    row_ok;
        x0       = {col_reg, 3'b000};
        dx0_next = PIX_W'(offx_reg) + $signed(PIX_W'(x0));
        dy_next  = PIX_W'(offy_reg) + $signed(PIX_W'(row_reg));
        row_ok   = (dy_next >= 0) && (dy_next < DH_S);
        for (int i = 0; i < 8; i++)
        begin
            x_b  = {1'b0, x0} + (BM_DIM_W + 1)'(i);
            dx_b = dx0_next + PIX_W'(i);
            mask8_next[7 - i] = byte_reg[7 - i] && row_ok
                                && (x_b < {1'b0, width_reg})
                                && (dx_b >= 0) && (dx_b < DW_S);
        end
    end

    assign stride  = ({1'b0, width_reg} + (BM_DIM_W + 1)'(7)) >> 3 > (BM_DIM_W + 1)'(0)
                     ? (COL_BYTE_W + 1)'(({1'b0, width_reg} + (BM_DIM_W + 1)'(7)) >> 3)
                     : '0;
    assign col_inc = {1'b0, col_reg} + (COL_BYTE_W + 1)'(1);
    assign base    = $signed(prod_reg) + BASE_W'(dx0_reg);
    assign addr_b  = addr_a_reg + FB_AW'(1);

    // configuration and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            offx_reg   <= '0;
            offy_reg   <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_BITMAP_WIDTH:  width_reg  <= cfg.data[BM_DIM_W-1:0];
                    CFG_BITMAP_HEIGHT: height_reg <= cfg.data[BM_DIM_W-1:0];
                    CFG_OFFSET_X:      offx_reg   <= $signed(cfg.data);
                    CFG_OFFSET_Y:      offy_reg   <= $signed(cfg.data);
                    default:           ;
                endcase
            end
            if (take_beat && (req.req_type == REQ_CLEAR))
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (cmd.calc)
            begin
                // wrap to the next row at the end of the stride
                if (col_inc >= stride)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + BM_DIM_W'(1);
                end
                else
                begin
                    col_reg <= col_inc[COL_BYTE_W-1:0];
                end
            end
        end
    end

    // clear sweep counter and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_beat && (req.req_type == REQ_CLEAR))
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + FB_AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_beat)
        begin
            byte_reg     <= req.src_bits;
            raddr_reg    <= req.read_addr;
            raddr_ok_reg <= CMP_W'(req.read_addr) < CMP_W'(FB_BYTES);
        end
        if (cmd.calc)
        begin
            mask8_reg <= mask8_next;
            dy_reg    <= dy_next[BM_DIM_W-1:0];
            dx0_reg   <= dx0_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= BASE_W'(dy_reg) * BASE_W'(DISPLAY_WIDTH);
        end
        if (cmd.addr)
        begin
            // an all-zero upper mask covers a negative base
            addr_a_reg <= base[FB_AW+2:3];
            mask16_reg <= 16'({mask8_reg, 8'h00} >> base[2:0]);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= raddr_ok_reg ? rdata_reg : '0;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_a_reg;
        mem_wdata = rdata_reg | mask16_reg[15:8];
        if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (cmd.wr_a)
        begin
            mem_we = (mask16_reg[15:8] != 8'h00);
        end
        else if (cmd.wr_b)
        begin
            mem_we    = (mask16_reg[7:0] != 8'h00);
            mem_waddr = addr_b;
            mem_wdata = rdata_reg | mask16_reg[7:0];
        end
    end

    assign mem_re    = cmd.rd_a || cmd.rd_b || cmd.rd_fb;
    assign mem_raddr = cmd.rd_fb ? FB_AW'(raddr_reg) : (cmd.rd_b ? addr_b : addr_a_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

FILE: rtl/mono_bitmap_blit_clip.sv
// ----------------------------------------------------------------------------
// mono_bitmap_blit_clip
// ORs a 1bpp source bitmap into a 1bpp framebuffer at a signed offset.
// ----------------------------------------------------------------------------
// Channels: req carries a request (clear, source byte or framebuffer read),
// rsp returns one byte per read request, cfg writes bitmap_width (0),
// bitmap_height (1), offset_x (2) and offset_y (3); cfg is always ready.
// Write cfg only while the block is idle.
// Sequence of each request:
//   source byte: clip, multiply, address, then two read-modify-writes;
//   a byte past the bitmap is dropped.
//   read: the framebuffer is read, then the byte loads into the result
//   register and rsp.valid rises; the next request is taken once it has
//   loaded, later while rsp is stalled.
//   clear: the whole framebuffer is zeroed, one byte per cycle.
// Reset runs the same clearing pass; req.ready stays low until it
// completes. The result register holds a read byte while rsp stalls;
// other requests are still taken, but a later read waits for the byte
// to move before it loads its own result and the next request is taken.
// ----------------------------------------------------------------------------
module mono_bitmap_blit_clip
#(
    parameter int DISPLAY_WIDTH  = mbb_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = mbb_pkg::DISPLAY_HEIGHT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    mbb_req_if.sink   req,
    mbb_rsp_if.source rsp,
    mbb_cfg_if.sink   cfg
);
    import mbb_pkg::*;

    mbb_cmd_t  cmd;
    mbb_stat_t stat;

    mbb_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    mbb_datapath
    #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    )
    u_datapath
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
